### sv/ras_pkg.sv
`timescale 1ns / 1ps

package ras_pkg;

    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_SET_TIME   = 3'd1,
        KIND_ADD_DAILY  = 3'd2,
        KIND_DEL_DAILY  = 3'd3,
        KIND_ADD_TIMER  = 3'd4,
        KIND_DEL_TIMER  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        RES_STATUS = 2'd0,
        RES_DAILY  = 2'd1,
        RES_TIMER  = 2'd2
    } t_res_kind;

    // Width of the tick counter and of the time field.
    localparam int TimeW = 32;
    // Steps of the time-of-day reduction: multiply, back-multiply, subtract, correct.
    localparam int ModSteps = 4;
    localparam int ModCntW  = 2;

    typedef struct packed {
        logic load;         // capture the request
        logic apply;        // immediate update of the request
        logic mod_step;     // one step of time-of-day reduction
        logic scan_clr;     // restart slot scan
        logic scan_step;    // examine one slot
        logic scan_timer;   // scan timers, else daily alarms
        logic fire;         // retire best slot and emit a firing
        logic day_adv;      // advance time of day
        logic sweep_step;   // recompute one done mark
        logic emit_status;  // emit the closing status
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic is_set;
        logic running;
        logic fwd;          // new time lies ahead of the tick count
        logic found;
        logic scan_last;
        logic mod_last;
        logic out_free;
    } t_sts;

endpackage

### sv/rtc_alarm_scheduler.sv
`timescale 1ns / 1ps

// Seconds clock with DAILY_SLOTS daily alarms and TIMER_SLOTS one-shot timers. Each request
// (tick, set time, add or remove an alarm or timer) produces its firings, timers before daily
// alarms, each kind ordered by time and then slot, followed by one status with tlast set. The
// block takes one request at a time. Add, remove, unknown kinds and a tick while stopped go
// straight to the status. A running tick scans the timers, advances the time of day and then
// scans the daily alarms: every firing costs one full pass over the slot store through a
// single comparator. A set time reduces the new time to a time of day (reciprocal multiply,
// back-multiply, subtract, one correction), runs the timer passes when the clock moves forward
// and then rebuilds the done marks. Output stalls hold up each of these sequences.
module rtc_alarm_scheduler #(
    parameter int DAILY_SLOTS = 16,
    parameter int TIMER_SLOTS = 16,
    parameter int DAY_LENGTH  = 86400
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // slot[3:0], time_value[35:4], zero[39:36]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // fired_slot[3:0], timed_out[4], accepted[5],
                                        // seconds_now[37:6], zero[39:38]
    output logic [1:0]  m_axis_tuser,   // result_kind[1:0]
    output logic        m_axis_tlast    // last
);
    import ras_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic [3:0]  fired_slot;
    logic        timed_out;
    logic        accepted;
    logic [31:0] seconds_now;

    ras_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ras_dp #(
        .DAILY_SLOTS (DAILY_SLOTS),
        .TIMER_SLOTS (TIMER_SLOTS),
        .DAY_LENGTH  (DAY_LENGTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_kind       (s_axis_tuser),
        .i_slot       (s_axis_tdata[3:0]),
        .i_tv         (s_axis_tdata[35:4]),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_res_kind   (m_axis_tuser),
        .o_fired_slot (fired_slot),
        .o_timed_out  (timed_out),
        .o_accepted   (accepted),
        .o_seconds    (seconds_now),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, seconds_now, accepted, timed_out, fired_slot};

    // a status closes each request, and only a status
    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == RES_STATUS)))
        else $error("tlast does not match a status result");

    // one request at a time: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while previous one in progress");

    // fired slot lies inside the store that fired it
    a_timer_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == RES_TIMER))
            |-> ({2'b00, m_axis_tdata[3:0]} < 6'(TIMER_SLOTS)))
        else $error("timer firing from a slot beyond the store");

    a_daily_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == RES_DAILY))
            |-> ({2'b00, m_axis_tdata[3:0]} < 6'(DAILY_SLOTS)) && m_axis_tdata[4])
        else $error("bad daily alarm firing");

endmodule

### sv/ras_ctrl.sv
`timescale 1ns / 1ps

module ras_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  ras_pkg::t_sts i_sts,
    output ras_pkg::t_cmd o_cmd
);
    import ras_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_MOD,
        S_TSCAN,
        S_TEVAL,
        S_DSCAN,
        S_DEVAL,
        S_SWEEP,
        S_STATUS
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_fwd;
    logic   n_fwd;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_fwd       = r_fwd;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                priority if (i_sts.is_tick && i_sts.running) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_TSCAN;
                end else if (i_sts.is_set) begin
                    n_fwd   = i_sts.fwd;
                    n_state = S_MOD;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = r_fwd ? S_TSCAN : S_SWEEP;
                end
            end
            S_TSCAN: begin
                o_cmd.scan_timer = 1'b1;
                o_cmd.scan_step  = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_TEVAL;
                end
            end
            S_TEVAL: begin
                o_cmd.scan_timer = 1'b1;
                priority if (i_sts.found) begin
                    // hold the winner until the output register frees up
                    if (i_sts.out_free) begin
                        o_cmd.fire     = 1'b1;
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_TSCAN;
                    end
                end else if (i_sts.is_tick) begin
                    o_cmd.day_adv  = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_DSCAN;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SWEEP;
                end
            end
            S_DSCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DEVAL;
                end
            end
            S_DEVAL: begin
                priority if (i_sts.found) begin
                    if (i_sts.out_free) begin
                        o_cmd.fire     = 1'b1;
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_DSCAN;
                    end
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fwd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fwd   <= n_fwd;
        end
    end

endmodule

### sv/ras_dp.sv
`timescale 1ns / 1ps

module ras_dp #(
    parameter int DAILY_SLOTS = 16,
    parameter int TIMER_SLOTS = 16,
    parameter int DAY_LENGTH  = 86400
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ras_pkg::t_cmd i_cmd,
    output ras_pkg::t_sts o_sts,
    input  logic [2:0]    i_kind,
    input  logic [3:0]    i_slot,
    input  logic [31:0]   i_tv,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_res_kind,
    output logic [3:0]    o_fired_slot,
    output logic          o_timed_out,
    output logic          o_accepted,
    output logic [31:0]   o_seconds,
    output logic          o_last
);
    import ras_pkg::*;

    localparam int DW  = $clog2(DAY_LENGTH);
    localparam int DIW = (DAILY_SLOTS > 1) ? $clog2(DAILY_SLOTS) : 1;
    localparam int TIW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int SW  = (DIW > TIW) ? DIW : TIW;
    // floor(2^32 / DAY_LENGTH); the quotient estimate is exact or one short
    localparam logic [TimeW-1:0] RecipM = TimeW'((64'd1 << TimeW) / DAY_LENGTH);

    // captured request
    logic [2:0]        r_kind;
    logic [3:0]        r_slot;
    logic [TimeW-1:0]  r_tv;

    // clock state
    logic [TimeW-1:0]  r_tick;
    logic [DW-1:0]     r_day;
    logic              r_running;

    // slot stores
    logic [DW-1:0]          r_dtime [DAILY_SLOTS];
    logic [DAILY_SLOTS-1:0] r_dvalid;
    logic [DAILY_SLOTS-1:0] r_ddone;
    logic [TimeW-1:0]       r_ttime [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] r_tvalid;

    logic              r_acc;

    // minimum search
    logic [SW-1:0]     r_idx;
    logic              r_found;
    logic [TimeW-1:0]  r_best_time;
    logic [SW-1:0]     r_best_idx;

    // time-of-day reduction by reciprocal multiplication
    logic [2*TimeW-1:0] r_mprod;
    logic [TimeW-1:0]   r_qd;
    logic [DW:0]        r_rest;
    logic [ModCntW-1:0] r_mod_cnt;

    // output register
    logic              r_ovalid;
    t_res_kind         r_okind;
    logic [3:0]        r_oslot;
    logic              r_otmo;
    logic              r_oacc;
    logic [TimeW-1:0]  r_osec;
    logic              r_olast;

    logic              is_tick;
    logic              is_set;
    logic              slot_d_ok;
    logic              slot_t_ok;
    logic [DIW-1:0]    d_sel;
    logic [TIW-1:0]    t_sel;
    logic              fwd;
    logic              acc_calc;
    logic [TIW-1:0]    ti;
    logic [DIW-1:0]    di;
    logic [TIW-1:0]    tb;
    logic [DIW-1:0]    db;
    logic [TimeW-1:0]  d_time_ext;
    logic              t_cand;
    logic              d_cand;
    logic              cand;
    logic              scan_last;
    logic              mod_ge;
    logic [DW-1:0]     rem_nxt;
    logic              mod_last;
    logic              out_free;
    logic              day_wrap;

    assign is_tick   = (r_kind == KIND_TICK);
    assign is_set    = (r_kind == KIND_SET_TIME);
    assign slot_d_ok = {2'b00, r_slot} < 6'(DAILY_SLOTS);
    assign slot_t_ok = {2'b00, r_slot} < 6'(TIMER_SLOTS);
    assign d_sel     = DIW'(r_slot);
    assign t_sel     = TIW'(r_slot);
    assign fwd       = r_tv > r_tick;

    always_comb begin
        unique case (r_kind)
            KIND_TICK:      acc_calc = r_running;
            KIND_SET_TIME:  acc_calc = 1'b1;
            KIND_ADD_DAILY: acc_calc = slot_d_ok && (r_tv < TimeW'(DAY_LENGTH));
            KIND_DEL_DAILY: acc_calc = slot_d_ok && r_dvalid[d_sel];
            KIND_ADD_TIMER: acc_calc = slot_t_ok && fwd;
            KIND_DEL_TIMER: acc_calc = slot_t_ok && r_tvalid[t_sel];
            default:        acc_calc = 1'b0;
        endcase
    end

    assign ti         = r_idx[TIW-1:0];
    assign di         = r_idx[DIW-1:0];
    assign tb         = r_best_idx[TIW-1:0];
    assign db         = r_best_idx[DIW-1:0];
    assign d_time_ext = TimeW'(r_dtime[di]);

    // strict less-than keeps the lowest slot among equal times
    assign t_cand = r_tvalid[ti] && (r_ttime[ti] <= r_tick)
                    && (!r_found || (r_ttime[ti] < r_best_time));
    assign d_cand = r_dvalid[di] && !r_ddone[di] && (r_dtime[di] <= r_day)
                    && (!r_found || (d_time_ext < r_best_time));
    assign cand   = i_cmd.scan_timer ? t_cand : d_cand;

    assign scan_last = i_cmd.scan_timer ? (r_idx == SW'(TIMER_SLOTS - 1))
                                        : (r_idx == SW'(DAILY_SLOTS - 1));

    assign mod_ge   = r_rest >= (DW + 1)'(DAY_LENGTH);
    assign rem_nxt  = mod_ge ? DW'(r_rest - (DW + 1)'(DAY_LENGTH)) : DW'(r_rest);
    assign mod_last = (r_mod_cnt == ModCntW'(ModSteps - 1));

    assign out_free = !r_ovalid || i_ready;
    assign day_wrap = (r_day == DW'(DAY_LENGTH - 1));

    assign o_sts.is_tick   = is_tick;
    assign o_sts.is_set    = is_set;
    assign o_sts.running   = r_running;
    assign o_sts.fwd       = fwd;
    assign o_sts.found     = r_found;
    assign o_sts.scan_last = scan_last;
    assign o_sts.mod_last  = mod_last;
    assign o_sts.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_day     <= '0;
            r_running <= 1'b0;
            r_dvalid  <= '0;
            r_ddone   <= '0;
            r_tvalid  <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_mod_cnt <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                unique case (r_kind)
                    KIND_TICK: begin
                        if (r_running) begin
                            r_tick <= r_tick + TimeW'(1);
                        end
                    end
                    KIND_SET_TIME: begin
                        r_tick    <= r_tv;
                        r_running <= 1'b1;
                        r_mod_cnt <= '0;
                    end
                    KIND_ADD_DAILY: begin
                        if (acc_calc) begin
                            r_dvalid[d_sel] <= 1'b1;
                            r_ddone[d_sel]  <= (r_tv[DW-1:0] <= r_day);
                        end
                    end
                    KIND_DEL_DAILY: begin
                        if (slot_d_ok) begin
                            r_dvalid[d_sel] <= 1'b0;
                            r_ddone[d_sel]  <= 1'b0;
                        end
                    end
                    KIND_ADD_TIMER: begin
                        if (acc_calc) begin
                            r_tvalid[t_sel] <= 1'b1;
                        end
                    end
                    KIND_DEL_TIMER: begin
                        if (slot_t_ok) begin
                            r_tvalid[t_sel] <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.mod_step) begin
                r_mod_cnt <= r_mod_cnt + ModCntW'(1);
                if (mod_last) begin
                    r_day <= rem_nxt;
                end
            end

            if (i_cmd.scan_clr) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + SW'(1);
                if (cand) begin
                    r_found <= 1'b1;
                end
            end else if (i_cmd.sweep_step) begin
                r_idx       <= r_idx + SW'(1);
                r_ddone[di] <= r_dvalid[di] && (r_dtime[di] <= r_day);
            end

            if (i_cmd.fire) begin
                if (i_cmd.scan_timer) begin
                    r_tvalid[tb] <= 1'b0;
                end else begin
                    r_ddone[db] <= 1'b1;
                end
            end

            if (i_cmd.day_adv) begin
                if (day_wrap) begin
                    r_day   <= '0;
                    r_ddone <= '0;
                end else begin
                    r_day <= r_day + DW'(1);
                end
            end

            if (i_cmd.fire || i_cmd.emit_status) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_slot <= i_slot;
            r_tv   <= i_tv;
        end

        if (i_cmd.apply) begin
            r_acc <= acc_calc;
            if ((r_kind == KIND_ADD_DAILY) && acc_calc) begin
                r_dtime[d_sel] <= r_tv[DW-1:0];
            end
            if ((r_kind == KIND_ADD_TIMER) && acc_calc) begin
                r_ttime[t_sel] <= r_tv;
            end
        end

        // estimate the quotient, multiply back, subtract; the last step corrects
        if (i_cmd.mod_step) begin
            unique case (r_mod_cnt)
                ModCntW'(0): r_mprod <= (2 * TimeW)'(r_tv) * (2 * TimeW)'(RecipM);
                ModCntW'(1): r_qd    <= r_mprod[2*TimeW-1:TimeW] * TimeW'(DAY_LENGTH);
                ModCntW'(2): r_rest  <= (DW + 1)'(r_tv - r_qd);
                default: begin
                end
            endcase
        end

        if (i_cmd.scan_step && cand) begin
            r_best_time <= i_cmd.scan_timer ? r_ttime[ti] : d_time_ext;
            r_best_idx  <= r_idx;
        end

        if (i_cmd.fire) begin
            r_okind <= i_cmd.scan_timer ? RES_TIMER : RES_DAILY;
            r_oslot <= 4'(r_best_idx);
            // timers caught up by a set time are not timed out
            r_otmo  <= i_cmd.scan_timer ? is_tick : 1'b1;
            r_oacc  <= 1'b0;
            r_osec  <= r_tick;
            r_olast <= 1'b0;
        end else if (i_cmd.emit_status) begin
            r_okind <= RES_STATUS;
            r_oslot <= '0;
            r_otmo  <= 1'b0;
            r_oacc  <= r_acc;
            r_osec  <= r_tick;
            r_olast <= 1'b1;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_res_kind   = r_okind;
    assign o_fired_slot = r_oslot;
    assign o_timed_out  = r_otmo;
    assign o_accepted   = r_oacc;
    assign o_seconds    = r_osec;
    assign o_last       = r_olast;

endmodule

### bench/ras_checker.sv
`timescale 1ns / 1ps

module ras_checker #(
    parameter int DAILY_SLOTS = 16,
    parameter int TIMER_SLOTS = 16,
    parameter int DAY_LENGTH  = 86400
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [39:0] i_req_data,   // slot[3:0], time_value[35:4], zero[39:36]
    input  logic [2:0]  i_req_user,   // kind[2:0]
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [39:0] i_res_data,   // fired_slot[3:0], timed_out[4], accepted[5],
                                      // seconds_now[37:6], zero[39:38]
    input  logic [1:0]  i_res_user,   // result_kind[1:0]
    input  logic        i_res_last,
    output int          o_errors,
    output int          o_pending
);
    import ras_pkg::*;

    typedef struct {
        t_res_kind   kind;
        logic [3:0]  slot;
        logic        timed_out;
        logic        accepted;
        logic [31:0] seconds;
        logic        last;
    } t_result;

    logic [31:0] clock_secs;
    logic [16:0] day_pos;
    logic        clock_running;
    logic [16:0] alarm_at    [DAILY_SLOTS];
    logic        alarm_armed [DAILY_SLOTS];
    logic        alarm_done  [DAILY_SLOTS];
    logic [31:0] timer_at    [TIMER_SLOTS];
    logic        timer_armed [TIMER_SLOTS];

    t_result due_results[$];
    int      err_count = 0;

    function automatic void push_result(t_res_kind kind, logic [3:0] slot, logic tmo,
                                        logic acc, logic last);
        t_result r;
        r.kind      = kind;
        r.slot      = slot;
        r.timed_out = tmo;
        r.accepted  = acc;
        r.seconds   = clock_secs;
        r.last      = last;
        due_results.push_back(r);
    endfunction

    // Retire due timers earliest first, lower slot on equal times.
    function automatic void fire_due_timers(logic by_tick);
        int best;
        do begin
            best = -1;
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                if (timer_armed[i] && timer_at[i] <= clock_secs &&
                    (best < 0 || timer_at[i] < timer_at[best])) begin
                    best = i;
                end
            end
            if (best >= 0) begin
                timer_armed[best] = 1'b0;
                push_result(RES_TIMER, 4'(best), by_tick, 1'b0, 1'b0);
            end
        end while (best >= 0);
    endfunction

    function automatic void fire_due_alarms();
        int best;
        do begin
            best = -1;
            for (int i = 0; i < DAILY_SLOTS; i++) begin
                if (alarm_armed[i] && !alarm_done[i] && alarm_at[i] <= day_pos &&
                    (best < 0 || alarm_at[i] < alarm_at[best])) begin
                    best = i;
                end
            end
            if (best >= 0) begin
                alarm_done[best] = 1'b1;
                push_result(RES_DAILY, 4'(best), 1'b1, 1'b0, 1'b0);
            end
        end while (best >= 0);
    endfunction

    function automatic void predict_request(logic [2:0] kind, logic [3:0] slot,
                                            logic [31:0] tv);
        logic ok;
        logic ahead;
        ok = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (clock_running) begin
                    ok = 1'b1;
                    clock_secs = clock_secs + 32'd1;
                    fire_due_timers(1'b1);
                    day_pos = day_pos + 17'd1;
                    if (day_pos >= DAY_LENGTH) begin
                        day_pos = '0;
                        foreach (alarm_done[i]) alarm_done[i] = 1'b0;
                    end
                    fire_due_alarms();
                end
            end
            KIND_SET_TIME: begin
                ahead = tv > clock_secs;
                ok = 1'b1;
                clock_running = 1'b1;
                clock_secs = tv;
                // only a forward jump catches up overdue timers
                if (ahead) begin
                    fire_due_timers(1'b0);
                end
                day_pos = 17'(tv % DAY_LENGTH);
                foreach (alarm_done[i]) begin
                    alarm_done[i] = alarm_armed[i] && alarm_at[i] <= day_pos;
                end
            end
            KIND_ADD_DAILY: begin
                if (slot < DAILY_SLOTS && tv < DAY_LENGTH) begin
                    ok = 1'b1;
                    alarm_at[slot]    = 17'(tv);
                    alarm_armed[slot] = 1'b1;
                    alarm_done[slot]  = 17'(tv) <= day_pos;
                end
            end
            KIND_DEL_DAILY: begin
                if (slot < DAILY_SLOTS) begin
                    ok = alarm_armed[slot];
                    alarm_armed[slot] = 1'b0;
                    alarm_done[slot]  = 1'b0;
                end
            end
            KIND_ADD_TIMER: begin
                if (slot < TIMER_SLOTS && tv > clock_secs) begin
                    ok = 1'b1;
                    timer_at[slot]    = tv;
                    timer_armed[slot] = 1'b1;
                end
            end
            KIND_DEL_TIMER: begin
                if (slot < TIMER_SLOTS) begin
                    ok = timer_armed[slot];
                    timer_armed[slot] = 1'b0;
                end
            end
            default: ;
        endcase
        push_result(RES_STATUS, 4'd0, 1'b0, ok, 1'b1);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clock_secs    = '0;
            day_pos       = '0;
            clock_running = 1'b0;
            foreach (alarm_at[i]) begin
                alarm_at[i]    = '0;
                alarm_armed[i] = 1'b0;
                alarm_done[i]  = 1'b0;
            end
            foreach (timer_at[i]) begin
                timer_at[i]    = '0;
                timer_armed[i] = 1'b0;
            end
            due_results.delete();
        end else begin
            // predict first so a same-edge result still meets an older expectation
            if (i_req_valid && i_req_ready) begin
                predict_request(i_req_user, i_req_data[3:0], i_req_data[35:4]);
            end
            if (i_res_valid && i_res_ready) begin
                if (due_results.size() == 0) begin
                    err_count++;
                    $display("%0t ns: unexpected result, expected none, actual %0d 0x%0h %0b",
                             $time, i_res_user, i_res_data, i_res_last);
                end else begin
                    want = due_results.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(i_res_user));
                    check_field("fired_slot", 32'(want.slot), 32'(i_res_data[3:0]));
                    check_field("timed_out", 32'(want.timed_out), 32'(i_res_data[4]));
                    check_field("accepted", 32'(want.accepted), 32'(i_res_data[5]));
                    check_field("seconds_now", want.seconds, i_res_data[37:6]);
                    check_field("last", 32'(want.last), 32'(i_res_last));
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= due_results.size();
    end

endmodule

### bench/rtc_alarm_scheduler_tb.sv
`timescale 1ns / 1ps

module rtc_alarm_scheduler_tb;
    import ras_pkg::*;

    localparam int DAILY_SLOTS = 16;
    localparam int TIMER_SLOTS = 16;
    localparam int DAY_LENGTH  = 86400;

    // Kinds the block does not define
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    localparam int RANDOM_REQS    = 450;
    localparam int CALM_REQS      = 80;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // slot[3:0], time_value[35:4], zero[39:36]
    logic [2:0]  s_axis_tuser = '0;   // kind[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // fired_slot[3:0], timed_out[4], accepted[5],
                                      // seconds_now[37:6], zero[39:38]
    logic [1:0]  m_axis_tuser;        // result_kind[1:0]
    logic        m_axis_tlast;

    int          errors;
    int          pending;
    bit          idle_on = 1'b1;
    bit          squeeze_now = 1'b0;
    bit          squeeze_done = 1'b0;
    logic [31:0] now_est = '0;
    bit          running_est = 1'b0;

    rtc_alarm_scheduler #(
        .DAILY_SLOTS(DAILY_SLOTS),
        .TIMER_SLOTS(TIMER_SLOTS),
        .DAY_LENGTH (DAY_LENGTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    ras_checker #(
        .DAILY_SLOTS(DAILY_SLOTS),
        .TIMER_SLOTS(TIMER_SLOTS),
        .DAY_LENGTH (DAY_LENGTH)
    ) u_result_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(s_axis_tvalid),
        .i_req_ready(s_axis_tready),
        .i_req_data (s_axis_tdata),
        .i_req_user (s_axis_tuser),
        .i_res_valid(m_axis_tvalid),
        .i_res_ready(m_axis_tready),
        .i_res_data (m_axis_tdata),
        .i_res_user (m_axis_tuser),
        .i_res_last (m_axis_tlast),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAIL rtc_alarm_scheduler");
        $finish;
    end

    // Offer one request, holding tvalid across back-to-back requests.
    task automatic send_request(input logic [2:0] kind, input logic [3:0] slot,
                                input logic [31:0] tv);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0000, tv, slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (kind == KIND_SET_TIME) begin
            now_est     = tv;
            running_est = 1'b1;
        end else if (kind == KIND_TICK && running_est) begin
            now_est = now_est + 32'd1;
        end
    endtask

    // Result side: random stalls, one long hold-off to back the block up
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (squeeze_now && !squeeze_done) begin
                m_axis_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
                squeeze_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int          pick;
        logic [31:0] tv;
        logic [16:0] day_est;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // clock stopped, nothing valid yet
        send_request(KIND_TICK, 4'd0, 32'd0);
        send_request(KIND_ADD_TIMER, 4'd0, 32'd0);
        send_request(KIND_DEL_DAILY, 4'd3, 32'd0);
        send_request(KIND_SPARE_6, 4'd15, 32'hFFFF_FFFF);
        send_request(KIND_SPARE_7, 4'd0, 32'h0000_0000);
        send_request(KIND_ADD_DAILY, 4'd15, DAY_LENGTH);
        send_request(KIND_ADD_DAILY, 4'd15, DAY_LENGTH - 1);
        send_request(KIND_ADD_DAILY, 4'd0, 32'd0);
        // start two seconds before midnight, timers tied on one second
        send_request(KIND_SET_TIME, 4'd0, DAY_LENGTH - 2);
        send_request(KIND_ADD_TIMER, 4'd5, DAY_LENGTH - 1);
        send_request(KIND_ADD_TIMER, 4'd2, DAY_LENGTH - 1);
        send_request(KIND_ADD_TIMER, 4'd9, DAY_LENGTH);
        send_request(KIND_TICK, 4'd0, 32'd0);
        send_request(KIND_TICK, 4'd0, 32'd0);
        send_request(KIND_ADD_DAILY, 4'd0, DAY_LENGTH - 1);
        send_request(KIND_ADD_DAILY, 4'd7, 32'd0);
        send_request(KIND_ADD_DAILY, 4'd8, 32'd1);
        send_request(KIND_ADD_TIMER, 4'd1, 32'hFFFF_FFFF);
        send_request(KIND_ADD_TIMER, 4'd3, 32'd100000);
        // backward jump, then forward to the edge of the counter
        send_request(KIND_SET_TIME, 4'd0, 32'd5);
        send_request(KIND_SET_TIME, 4'd0, 32'hFFFF_FFFE);
        send_request(KIND_TICK, 4'd0, 32'd0);
        send_request(KIND_TICK, 4'd0, 32'd0);
        send_request(KIND_DEL_DAILY, 4'd15, 32'd0);
        send_request(KIND_DEL_TIMER, 4'd5, 32'd0);
        send_request(KIND_ADD_TIMER, 4'd4, 32'd0);

        squeeze_now = 1'b1;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == RANDOM_REQS - CALM_REQS) begin
                idle_on = 1'b0;
            end
            day_est = 17'(now_est % DAY_LENGTH);
            pick = $urandom_range(0, 99);
            if (pick < 54) begin
                send_request(KIND_TICK, 4'($urandom_range(0, 15)), $urandom());
            end else if (pick < 69) begin
                // mostly timers a few seconds ahead, so ticks keep firing them
                case ($urandom_range(0, 5))
                    0: tv = now_est - $urandom_range(0, 3);
                    1: tv = $urandom();
                    default: tv = now_est + $urandom_range(1, 12);
                endcase
                send_request(KIND_ADD_TIMER, 4'($urandom_range(0, 15)), tv);
            end else if (pick < 81) begin
                case ($urandom_range(0, 5))
                    0: tv = DAY_LENGTH + $urandom_range(0, 1000);
                    1: tv = $urandom_range(0, DAY_LENGTH - 1);
                    default: tv = (day_est + $urandom_range(0, 8)) % DAY_LENGTH;
                endcase
                send_request(KIND_ADD_DAILY, 4'($urandom_range(0, 15)), tv);
            end else if (pick < 87) begin
                send_request(KIND_DEL_DAILY, 4'($urandom_range(0, 15)), $urandom());
            end else if (pick < 93) begin
                send_request(KIND_DEL_TIMER, 4'($urandom_range(0, 15)), $urandom());
            end else if (pick < 98) begin
                case ($urandom_range(0, 4))
                    0: tv = now_est - $urandom_range(1, 50);
                    1, 2: tv = now_est - day_est + DAY_LENGTH - $urandom_range(1, 4);
                    3: tv = 32'hFFFF_FFFF - $urandom_range(0, 20);
                    default: tv = now_est + $urandom_range(0, 20);
                endcase
                send_request(KIND_SET_TIME, 4'($urandom_range(0, 15)), tv);
            end else begin
                send_request(($urandom_range(0, 1) != 0) ? KIND_SPARE_6 : KIND_SPARE_7,
                             4'($urandom_range(0, 15)), $urandom());
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS rtc_alarm_scheduler");
        end else begin
            $display("FAIL rtc_alarm_scheduler");
        end
        $finish;
    end

endmodule

### files.f
sv/ras_pkg.sv
sv/ras_ctrl.sv
sv/ras_dp.sv
sv/rtc_alarm_scheduler.sv
bench/ras_checker.sv
bench/rtc_alarm_scheduler_tb.sv
